// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the top level of the box mean filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/core/bmf_pkg.sv -----
// Package with constants, register map and state type of the box mean filter.
package bmf_pkg;

  // Default sizing of the line store.
  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxRadiusDef = 9;

  // Fixed limits that follow from the register widths.
  localparam int unsigned HeightLimit = 1024;
  localparam int unsigned RowW        = 11;
  localparam int unsigned PixW        = 8;
  localparam int unsigned PixMax      = 255;

  // Register indexes (paddr[3:2]).
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Main sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_LAST,
    S_DIV,
    S_DONE
  } bmf_state_e;

endpackage

// ----- rtl/core/bmf_line_mem.sv -----
// Line store: one write port and one registered read port.
module bmf_line_mem #(
  parameter int unsigned Depth = 19456,
  parameter int unsigned AddrW = 15,
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port: data is valid in the cycle after a read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/core/box_mean_filter_zero_padded.sv -----
// Top level of the zero-padded box mean filter.
//
//  channel   dir  transfer when              payload
//  s_axis    in   s_axis_tvalid & tready     tdata[7:0] pixel_in, tuser[0] cmd
//  m_axis    out  m_axis_tvalid & tready     tdata[7:0] pixel_out, tlast frame_last
//  apb       in   psel&penable&pwrite&pready radius, image_width, image_height
//
// An item that produces no output is accepted and the block stays idle. For an
// item that produces an output the window is then walked cell by cell, reading
// the line store only for cells inside the image; the last state lets the final
// read reach the sum, the bit-serial divider takes SumW (17 at default sizing)
// steps and the done state loads the output register. Reset is asynchronous and
// active low; the line store is not cleared. A stalled output holds the next
// result in the done state and blocks the input until that result is loaded.
module box_mean_filter_zero_padded
  import bmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_RADIUS = MaxRadiusDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] pixel_out
  output logic        m_axis_tlast,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  localparam int unsigned Rows    = 2 * MAX_RADIUS + 1;
  localparam int unsigned Depth   = Rows * MAX_WIDTH;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned ColW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RadW    = $clog2(MAX_RADIUS + 1);
  localparam int unsigned CrdW    = ((ColW > RowW) ? ColW : RowW) + 2;
  localparam int unsigned AreaMax = Rows * Rows;
  localparam int unsigned AreaW   = $clog2(AreaMax + 1);
  localparam int unsigned SumMax  = AreaMax * PixMax;
  localparam int unsigned SumW    = $clog2(SumMax + 1);
  localparam int unsigned DivCntW = $clog2(SumW);
  localparam int unsigned CntW    =
    $clog2(MAX_WIDTH * HeightLimit + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);

  // Configuration registers.
  logic [3:0]  radius_q;
  logic [10:0] width_q, height_q;
  logic        cfg_wr;

  // Effective values.
  logic [RadW-1:0]          r_eff;
  logic [ColW-1:0]          w_eff;
  logic [RowW-1:0]          h_eff;
  logic [RadW:0]            side;
  logic [2*(RadW+1)-1:0]    area_full;
  logic [AreaW-1:0]         area;
  logic [CntW-1:0]          lag;

  // Frame counters.
  logic [RowW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [ColW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [CntW-1:0]  qin_q, qin_d, pout_q, pout_d;
  logic [AddrW-1:0] wp_q, wp_d, op_q, op_d;

  // Window walk.
  logic signed [CrdW-1:0] rr_q, rr_d, cc_q, cc_d;
  logic signed [CrdW-1:0] end_row_q, end_row_d, end_col_q, end_col_d;
  logic signed [CrdW-1:0] start_col_q, start_col_d;
  logic [AddrW-1:0]       rb_q, rb_d, rp_q, rp_d;
  logic [AddrW:0]         win_base, rb_sum;
  logic [AddrW-1:0]       rb_next, rp_inc;
  logic                   last_q, last_d;
  logic                   rd_pend_q, rd_pend_d;
  logic [SumW-1:0]        sum_q, sum_d;

  // Divider.
  logic [SumW-1:0]    quo_q, quo_d;
  logic [AreaW-1:0]   rem_q, rem_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic [AreaW:0]     trial;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic [PixW-1:0] out_pix_q, out_pix_d;
  logic            out_last_q, out_last_d;

  bmf_state_e state_q, state_d;

  // Memory ports.
  logic             mem_we, rd_en, in_bounds;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [PixW-1:0]  rd_data;

  logic s_xfer, m_xfer, in_open, is_flush, emit;

  // Configuration port: always ready, writes to the three registers restart the frame.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[3:2] != 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 4'd1;
      width_q  <= 11'd640;
      height_q <= 11'd480;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_RADIUS: radius_q <= pwdata[3:0];
        REG_WIDTH:  width_q  <= pwdata[10:0];
        REG_HEIGHT: height_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS: prdata = {28'd0, radius_q};
      REG_WIDTH:  prdata = {21'd0, width_q};
      REG_HEIGHT: prdata = {21'd0, height_q};
      default:    prdata = 32'd0;
    endcase
  end

  // Saturate the registers into their legal ranges.
  always_comb begin
    r_eff = (32'(radius_q) > MAX_RADIUS) ? RadW'(MAX_RADIUS) : RadW'(radius_q);
    if (width_q == 11'd0) begin
      w_eff = ColW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = ColW'(MAX_WIDTH);
    end else begin
      w_eff = ColW'(width_q);
    end
    if (height_q == 11'd0) begin
      h_eff = RowW'(1);
    end else if (32'(height_q) > HeightLimit) begin
      h_eff = RowW'(HeightLimit);
    end else begin
      h_eff = height_q;
    end
  end

  assign side      = {r_eff, 1'b1};
  assign area_full = {{(RadW+1){1'b0}}, side} * {{(RadW+1){1'b0}}, side};
  assign area      = area_full[AreaW-1:0];
  assign lag       = CntW'(r_eff) * CntW'(w_eff) + CntW'(r_eff);

  // Handshakes.
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign m_xfer        = m_axis_tvalid && m_axis_tready;
  assign in_open       = (in_row_q < h_eff);
  assign is_flush      = s_axis_tuser[0];
  assign emit          = (qin_q >= pout_q + lag);

  // The store is a ring addressed by the raster index modulo its depth.
  assign mem_we  = s_xfer && !is_flush && in_open;
  assign wr_addr = wp_q;

  // Window read address and bounds.
  assign in_bounds = (rr_q >= 0) && (rr_q < $signed(CrdW'(h_eff))) &&
                     (cc_q >= 0) && (cc_q < $signed(CrdW'(w_eff)));
  assign rd_en     = (state_q == S_READ) && in_bounds;
  assign rd_addr   = rp_q;

  bmf_line_mem #(
    .Depth (Depth),
    .AddrW (AddrW),
    .DataW (PixW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_addr),
    .wdata_i (s_axis_tdata[7:0]),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Divider step: one quotient bit per cycle.
  assign trial = {rem_q, quo_q[SumW-1]};

  // Ring position of the window's top left cell, and the walk increments.
  assign win_base = ({1'b0, op_q} >= (AddrW+1)'(lag)) ?
                    {1'b0, op_q} - (AddrW+1)'(lag) :
                    {1'b0, op_q} + (AddrW+1)'(Depth) - (AddrW+1)'(lag);
  assign rb_sum   = {1'b0, rb_q} + (AddrW+1)'(w_eff);
  assign rb_next  = (rb_sum >= (AddrW+1)'(Depth)) ?
                    AddrW'(rb_sum - (AddrW+1)'(Depth)) : rb_sum[AddrW-1:0];
  assign rp_inc   = (32'(rp_q) == Depth - 1) ? '0 : rp_q + AddrW'(1);

  // Sequencer, counters and datapath.
  always_comb begin
    state_d     = state_q;
    in_row_d    = in_row_q;
    in_col_d    = in_col_q;
    qin_d       = qin_q;
    wp_d        = wp_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    pout_d      = pout_q;
    op_d        = op_q;
    rr_d        = rr_q;
    cc_d        = cc_q;
    rb_d        = rb_q;
    rp_d        = rp_q;
    end_row_d   = end_row_q;
    end_col_d   = end_col_q;
    start_col_d = start_col_q;
    last_d      = last_q;
    rd_pend_d   = rd_en;
    sum_d       = rd_pend_q ? sum_q + SumW'(rd_data) : sum_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = m_xfer ? 1'b0 : out_valid_q;
    out_pix_d   = out_pix_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (s_xfer && !(is_flush && in_open)) begin
          // Advance the input position.
          qin_d = qin_q + CntW'(1);
          wp_d  = (32'(wp_q) == Depth - 1) ? '0 : wp_q + AddrW'(1);
          if (in_col_q + ColW'(1) >= w_eff) begin
            in_col_d = '0;
            in_row_d = in_row_q + RowW'(1);
          end else begin
            in_col_d = in_col_q + ColW'(1);
          end
          if (emit) begin
            // Latch the window around the next output position.
            rr_d        = $signed(CrdW'(out_row_q)) - $signed(CrdW'(r_eff));
            cc_d        = $signed(CrdW'(out_col_q)) - $signed(CrdW'(r_eff));
            start_col_d = $signed(CrdW'(out_col_q)) - $signed(CrdW'(r_eff));
            end_row_d   = $signed(CrdW'(out_row_q)) + $signed(CrdW'(r_eff));
            end_col_d   = $signed(CrdW'(out_col_q)) + $signed(CrdW'(r_eff));
            rb_d        = win_base[AddrW-1:0];
            rp_d        = win_base[AddrW-1:0];
            sum_d       = '0;
            last_d      = (out_row_q == h_eff - RowW'(1)) &&
                          (out_col_q == w_eff - ColW'(1));
            state_d     = S_READ;
            if (last_d) begin
              in_row_d  = '0;
              in_col_d  = '0;
              qin_d     = '0;
              wp_d      = '0;
              out_row_d = '0;
              out_col_d = '0;
              pout_d    = '0;
              op_d      = '0;
            end else begin
              pout_d = pout_q + CntW'(1);
              op_d   = (32'(op_q) == Depth - 1) ? '0 : op_q + AddrW'(1);
              if (out_col_q + ColW'(1) >= w_eff) begin
                out_col_d = '0;
                out_row_d = out_row_q + RowW'(1);
              end else begin
                out_col_d = out_col_q + ColW'(1);
              end
            end
          end
        end
      end

      S_READ: begin
        // Walk the window row by row, one cell per cycle; the store is read only for cells inside the image.
        if (cc_q == end_col_q) begin
          cc_d = start_col_q;
          rr_d = rr_q + CrdW'(1);
          rb_d = rb_next;
          rp_d = rb_next;
          if (rr_q == end_row_q) begin
            state_d = S_LAST;
          end
        end else begin
          cc_d = cc_q + CrdW'(1);
          rp_d = rp_inc;
        end
      end

      S_LAST: begin
        // The last read lands in the sum this cycle.
        quo_d     = sum_d;
        rem_d     = '0;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end

      S_DIV: begin
        if (trial >= {1'b0, area}) begin
          rem_d = AreaW'(trial - {1'b0, area});
          quo_d = {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = trial[AreaW-1:0];
          quo_d = {quo_q[SumW-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + DivCntW'(1);
        if (32'(div_cnt_q) == SumW - 1) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_pix_d   = quo_q[PixW-1:0];
          out_last_d  = last_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // A register write restarts the frame.
    if (cfg_wr) begin
      in_row_d  = '0;
      in_col_d  = '0;
      qin_d     = '0;
      wp_d      = '0;
      out_row_d = '0;
      out_col_d = '0;
      pout_d    = '0;
      op_d      = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_row_q    <= '0;
      in_col_q    <= '0;
      qin_q       <= '0;
      wp_q        <= '0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      pout_q      <= '0;
      op_q        <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      in_row_q    <= in_row_d;
      in_col_q    <= in_col_d;
      qin_q       <= qin_d;
      wp_q        <= wp_d;
      out_row_q   <= out_row_d;
      out_col_q   <= out_col_d;
      pout_q      <= pout_d;
      op_q        <= op_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rr_q        <= rr_d;
    cc_q        <= cc_d;
    rb_q        <= rb_d;
    rp_q        <= rp_d;
    end_row_q   <= end_row_d;
    end_col_q   <= end_col_d;
    start_col_q <= start_col_d;
    last_q      <= last_d;
    sum_q       <= sum_d;
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    out_pix_q   <= out_pix_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  // Checks.
  `ASSERT_CLK(a_sum_bound, (state_q == S_LAST) |-> (sum_q <= SumW'(SumMax)),
              "window sum exceeds its bound")
  `ASSERT_CLK(a_load_from_done, $rose(m_axis_tvalid) |-> $past(state_q == S_DONE),
              "output loaded outside the done state")
  `ASSERT_CLK(a_div_length,
              (state_q == S_DIV && 32'(div_cnt_q) == SumW - 1) |=> (state_q == S_DONE),
              "divider did not finish on its last step")
  `ASSERT_ALWAYS(a_rd_addr_range, rd_en |-> (32'(rd_addr) < Depth),
                 "line store read beyond its depth")

endmodule

// ----- tb/box_mean_filter_zero_padded_test.sv -----
// Self-checking testbench for the zero-padded box mean filter, with a predictor and random stalls.
module box_mean_filter_zero_padded_test;
  import bmf_pkg::*;

  localparam int unsigned StoreDepth = (2 * MaxRadiusDef + 1) * MaxWidthDef;
  localparam int unsigned TimeoutCycles = 3000000;
  localparam int unsigned SettleCycles = 500;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pix;
  } pixel_item_t;

  typedef struct packed {
    logic [7:0] mean;
    logic       last;
  } mean_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] pixel_in
  logic [0:0]  s_axis_tuser = '0;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] pixel_out
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  box_mean_filter_zero_padded dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state: configuration, frame counters and a copy of the line store.
  logic [3:0]  cfg_radius = 4'd1;
  logic [10:0] cfg_width = 11'd640;
  logic [10:0] cfg_height = 11'd480;
  int unsigned slot_row, slot_col, emit_row, emit_col;
  logic [7:0]  pix_store [StoreDepth];

  pixel_item_t pending_pixels[$];
  mean_item_t  expected_means[$];
  pixel_item_t cur_item;
  logic        holding = 1'b0;
  logic        sender_hold = 1'b0;
  int unsigned send_gap = 0, recv_gap = 0;
  bit          send_burst = 0, recv_burst = 0;
  int unsigned mismatches = 0, means_seen = 0, pixels_sent = 0, phases = 0;
  int unsigned cycles = 0;

  function automatic int unsigned draw_gap(bit burst);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (burst || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Work out the result, if any, of one accepted input item.
  function automatic void predict_mean(pixel_item_t it);
    int unsigned r, w, h, total, lag, qin, pout, sum, area;
    int rr, cc;
    mean_item_t m;
    r = (cfg_radius > MaxRadiusDef) ? MaxRadiusDef : cfg_radius;
    w = (cfg_width < 1) ? 1 : (cfg_width > MaxWidthDef) ? MaxWidthDef : cfg_width;
    h = (cfg_height < 1) ? 1 : (cfg_height > HeightLimit) ? HeightLimit : cfg_height;
    total = w * h;
    lag = r * w + r;
    qin = slot_row * w + slot_col;
    pout = emit_row * w + emit_col;
    sum = 0;
    if (!it.cmd) begin
      if (qin < total) pix_store[qin % StoreDepth] = it.pix;
    end else if (qin < total) begin
      return;
    end
    slot_col++;
    if (slot_col >= w) begin
      slot_col = 0;
      slot_row++;
    end
    if (qin < pout + lag) return;
    for (rr = int'(emit_row) - int'(r); rr <= int'(emit_row) + int'(r); rr++) begin
      if (rr < 0 || rr >= int'(h)) continue;
      for (cc = int'(emit_col) - int'(r); cc <= int'(emit_col) + int'(r); cc++) begin
        if (cc < 0 || cc >= int'(w)) continue;
        sum += pix_store[(rr * w + cc) % StoreDepth];
      end
    end
    area = (2 * r + 1) * (2 * r + 1);
    m.mean = 8'((sum / area) & 8'hFF);
    m.last = (pout + 1 >= total);
    if (m.last) begin
      slot_row = 0; slot_col = 0; emit_row = 0; emit_col = 0;
    end else begin
      emit_col++;
      if (emit_col >= w) begin
        emit_col = 0;
        emit_row++;
      end
    end
    expected_means.push_back(m);
  endfunction

  // Input driver: presents queued items with random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_mean(cur_item);
        holding = 1'b0;
        pixels_sent++;
        if ($urandom_range(0, 99) < 2) send_burst = !send_burst;
        send_gap = draw_gap(send_burst);
      end
      if (!holding) begin
        if (send_gap > 0) send_gap--;
        else if (!sender_hold && pending_pixels.size() > 0) begin
          cur_item = pending_pixels.pop_front();
          holding = 1'b1;
        end
      end
      s_axis_tvalid <= holding;
      s_axis_tdata <= cur_item.pix;
      s_axis_tuser <= cur_item.cmd;
    end
  end

  // Output monitor: random back-pressure and comparison against the predictor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        means_seen++;
        if (expected_means.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: mean %0d last %0b", m_axis_tdata, m_axis_tlast);
        end else begin
          mean_item_t e;
          e = expected_means.pop_front();
          if (e.mean !== m_axis_tdata || e.last !== m_axis_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected mean %0d last %0b, got mean %0d last %0b",
                       e.mean, e.last, m_axis_tdata, m_axis_tlast);
          end
        end
        if ($urandom_range(0, 99) < 3) recv_burst = !recv_burst;
        recv_gap = draw_gap(recv_burst);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > TimeoutCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Wait until every queued item is in and every result is out, then let the block settle.
  task automatic settle();
    while (pending_pixels.size() > 0 || holding || s_axis_tvalid || expected_means.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RADIUS: cfg_radius = val[3:0];
      REG_WIDTH:  cfg_width = val[10:0];
      default:    cfg_height = val[10:0];
    endcase
    slot_row = 0; slot_col = 0; emit_row = 0; emit_col = 0;
  endtask

  task automatic configure(int unsigned r, int unsigned w, int unsigned h);
    settle();
    reg_write(REG_RADIUS, r);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    phases++;
  endtask

  // Queue the start of a frame: random pixels only, no flush ticks.
  task automatic queue_partial(int unsigned n);
    pixel_item_t it;
    for (int unsigned i = 0; i < n; i++) begin
      it.cmd = 1'b0;
      it.pix = 8'($urandom);
      pending_pixels.push_back(it);
    end
  endtask

  // Queue one frame: its pixels, then flush ticks, with optional noise.
  // Mode 0 random, 1 all white, 2 all black. Noise adds early flushes and
  // pixels past the frame end. Truncate queues only part of the pixels and no flush ticks.
  task automatic queue_frame(int unsigned r, int unsigned w, int unsigned h,
                             int unsigned mode, bit noise, bit truncate);
    int unsigned re, we, he, total, lag, n;
    pixel_item_t it;
    re = (r > MaxRadiusDef) ? MaxRadiusDef : r;
    we = (w < 1) ? 1 : (w > MaxWidthDef) ? MaxWidthDef : w;
    he = (h < 1) ? 1 : (h > HeightLimit) ? HeightLimit : h;
    total = we * he;
    lag = re * we + re;
    n = truncate ? $urandom_range(0, total) : total;
    for (int unsigned i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 9) == 0) begin
        it.cmd = 1'b1; it.pix = 8'($urandom);
        pending_pixels.push_back(it);
      end
      it.cmd = 1'b0;
      it.pix = (mode == 1) ? 8'hFF : (mode == 2) ? 8'h00 : 8'($urandom);
      pending_pixels.push_back(it);
    end
    if (truncate) return;
    for (int unsigned i = 0; i < lag; i++) begin
      it.cmd = !(noise && $urandom_range(0, 3) == 0);
      it.pix = 8'($urandom);
      pending_pixels.push_back(it);
    end
  endtask

  initial begin
    int unsigned r, w, h;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest image, saturating registers and the start of the largest frames.
    configure(0, 1, 1);
    queue_frame(0, 1, 1, 1, 0, 0);
    queue_frame(0, 1, 1, 2, 1, 0);
    configure(1, 3, 3);
    queue_frame(1, 3, 3, 1, 1, 0);
    configure(15, 4, 2);
    queue_frame(15, 4, 2, 1, 0, 0);
    configure(9, 0, 0);
    queue_frame(9, 0, 0, 0, 1, 0);
    configure(0, 2047, 1);
    queue_partial(40);
    configure(1, 1, 2047);
    queue_partial(40);
    configure(2, 5, 4);
    queue_frame(2, 5, 4, 0, 1, 1);

    // Random phases, mostly complete frames with random content.
    while (pixels_sent + pending_pixels.size() < 650) begin
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      configure(r, w, h);
      repeat ($urandom_range(1, 2))
        queue_frame(r, w, h, ($urandom_range(0, 9) == 0) ? 1 : 0,
                    $urandom_range(0, 3) == 0, $urandom_range(0, 11) == 0);
      // Hold the sender mid-stream until the block has caught up, at least
      // in the first random phase.
      if (phases == 8 || $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 40)) @(posedge clk_i);
        sender_hold = 1'b1;
        while (holding || s_axis_tvalid || expected_means.size() > 0) @(posedge clk_i);
        sender_hold = 1'b0;
      end
    end

    settle();
    $display("covered %0d configurations, %0d input transfers, %0d output transfers",
             phases, pixels_sent, means_seen);
    $display("radius 0 to 9 with saturation, widths 1 to 1024, heights 1 to 1024");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
